// ----- src/text_console_cursor_engine_top_defines.svh -----
// Assertion macros shared by the cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tcce_pkg.sv -----
// Types and constants shared by the cursor engine modules.
package tcce_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;

  // Effective caps on the column and row limits at register width.
  localparam logic [6:0] COL_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
  localparam logic [5:0] ROW_CAP = (MAX_ROWS > 63) ? 6'd63 : 6'(MAX_ROWS);

  localparam int CHAIN_LEN  = 8;
  localparam int LOAD_SLOTS = 4;
  localparam int LOAD_BASE  = CHAIN_LEN - LOAD_SLOTS;
  localparam int CNT_W      = $clog2(LOAD_SLOTS + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_TOP = 3'd4;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_BS = 8'd8;

  localparam logic [6:0]  RST_COLUMNS    = 7'd80;
  localparam logic [5:0]  RST_ROWS       = 6'd25;
  localparam logic [7:0]  RST_CURSOR     = 8'd127;
  localparam logic [23:0] RST_COLOR      = 24'd0;
  localparam logic [5:0]  RST_SCROLL_TOP = 6'd4;

  typedef enum logic [1:0] {
    OP_ERASE  = 2'd0,
    OP_DRAW   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SCROLL = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  glyph;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [23:0] color;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } slot_t;

  typedef struct packed {
    logic [6:0]  columns;
    logic [5:0]  rows;
    logic [7:0]  cursor_glyph;
    logic [23:0] text_color;
    logic [5:0]  scroll_top;
  } cfg_t;

endpackage

// ----- src/tcce_cell.sv -----
// One cell of the command chain: holds one command and hands it downstream.
module tcce_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv_in,
  output logic            adv_out,
  input  logic            ld_en,
  input  tcce_pkg::cmd_t  ld_cmd,
  input  tcce_pkg::slot_t up,
  output tcce_pkg::slot_t q
);

  tcce_pkg::slot_t slot_r;
  tcce_pkg::slot_t slot_nxt;

  // Move when empty or when the downstream cell takes this one.
  assign adv_out = !slot_r.valid || adv_in;
  assign q       = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (adv_out) begin
      if (ld_en) begin
        slot_nxt.valid = 1'b1;
        slot_nxt.cmd   = ld_cmd;
      end else begin
        slot_nxt = up;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r.cmd <= slot_nxt.cmd;
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

endmodule

// ----- src/tcce_decode.sv -----
// Character decoder: builds the command list and the next cursor position.
module tcce_decode (
  input  logic            [7:0] char_code,
  input  logic            [5:0] cur_row,
  input  logic            [6:0] cur_col,
  input  tcce_pkg::cfg_t        cfg,
  output tcce_pkg::slot_t       slots [tcce_pkg::LOAD_SLOTS],
  output logic            [5:0] new_row,
  output logic            [6:0] new_col
);

  function automatic tcce_pkg::cmd_t mk(tcce_pkg::op_t op, logic [7:0] g,
                                        logic [5:0] r, logic [6:0] c,
                                        logic [23:0] clr);
    tcce_pkg::cmd_t m;
    m.op    = op;
    m.glyph = g;
    m.row   = r;
    m.col   = c;
    m.color = clr;
    m.last  = 1'b0;
    return m;
  endfunction

  logic [6:0] ncols;
  logic [5:0] nrows;
  logic [6:0] row_inc;
  logic [7:0] col_inc;
  logic       row_sat;
  logic [5:0] row_down;
  logic       col_wrap;
  logic [6:0] col_m1;
  logic [tcce_pkg::CNT_W-1:0] n;
  tcce_pkg::cmd_t cmds [tcce_pkg::LOAD_SLOTS];
  tcce_pkg::cmd_t scroll_cmd;

  always_comb begin
    ncols = (cfg.columns == 7'd0) ? 7'd1 : cfg.columns;
    if (ncols > tcce_pkg::COL_CAP) ncols = tcce_pkg::COL_CAP;
    nrows = (cfg.rows == 6'd0) ? 6'd1 : cfg.rows;
    if (nrows > tcce_pkg::ROW_CAP) nrows = tcce_pkg::ROW_CAP;

    row_inc  = {1'b0, cur_row} + 7'd1;
    row_sat  = row_inc >= {1'b0, nrows};
    row_down = row_sat ? (nrows - 6'd1) : row_inc[5:0];
    col_inc  = {1'b0, cur_col} + 8'd1;
    col_wrap = col_inc >= {1'b0, ncols};
    col_m1   = cur_col - 7'd1;

    scroll_cmd = mk(tcce_pkg::OP_SCROLL, 8'd0, cfg.scroll_top, 7'd0, 24'd0);
    for (int k = 0; k < tcce_pkg::LOAD_SLOTS; k++) cmds[k] = '0;
    cmds[0] = mk(tcce_pkg::OP_ERASE, cfg.cursor_glyph, cur_row, cur_col, 24'd0);
    new_row = cur_row;
    new_col = cur_col;
    n       = tcce_pkg::CNT_W'(1);

    case (char_code)
      tcce_pkg::CH_CR: begin
        new_col = 7'd0;
        cmds[1] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, cur_row, 7'd0, cfg.text_color);
        n = tcce_pkg::CNT_W'(2);
      end
      tcce_pkg::CH_LF: begin
        new_row = row_down;
        if (row_sat) begin
          cmds[1] = scroll_cmd;
          cmds[2] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, row_down, cur_col,
                       cfg.text_color);
          n = tcce_pkg::CNT_W'(3);
        end else begin
          cmds[1] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, row_down, cur_col,
                       cfg.text_color);
          n = tcce_pkg::CNT_W'(2);
        end
      end
      tcce_pkg::CH_BS: begin
        // At column zero only the erase goes out; the cursor stays hidden.
        if (cur_col != 7'd0) begin
          new_col = col_m1;
          cmds[1] = mk(tcce_pkg::OP_CLEAR, 8'd0, cur_row, col_m1, 24'd0);
          cmds[2] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, cur_row, col_m1,
                       cfg.text_color);
          n = tcce_pkg::CNT_W'(3);
        end
      end
      default: begin
        cmds[1] = mk(tcce_pkg::OP_DRAW, char_code, cur_row, cur_col, cfg.text_color);
        new_col = col_wrap ? 7'd0 : col_inc[6:0];
        new_row = col_wrap ? row_down : cur_row;
        if (col_wrap && row_sat) begin
          cmds[2] = scroll_cmd;
          cmds[3] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, row_down, 7'd0,
                       cfg.text_color);
          n = tcce_pkg::CNT_W'(4);
        end else begin
          cmds[2] = mk(tcce_pkg::OP_DRAW, cfg.cursor_glyph, new_row, new_col,
                       cfg.text_color);
          n = tcce_pkg::CNT_W'(3);
        end
      end
    endcase

    for (int k = 0; k < tcce_pkg::LOAD_SLOTS; k++) begin
      slots[k].valid    = tcce_pkg::CNT_W'(k) < n;
      slots[k].cmd      = cmds[k];
      slots[k].cmd.last = tcce_pkg::CNT_W'(k + 1) == n;
    end
  end

endmodule

// ----- src/text_console_cursor_engine_top.sv -----
// Top level of the text console cursor engine: config, cursor and command chain.
//
// Use: send one character code per item on the in_ channel (in_valid,
// in_stall, in_char_code). Each character yields one to four framebuffer
// commands on the out_ channel (out_valid, out_stall and the command fields);
// out_last marks the final command of a character. Registers are written on
// the cfg_ channel (cfg_valid, cfg_ready, cfg_index, cfg_data) while idle;
// cfg_ready is always high and writes beyond the register list are dropped.
// Path: the first command of a character enters the chain at its fifth cell and
// steps one cell per cycle toward the output while out_stall is low.
// Throughput: the output drains one command per cycle while out_stall is low;
// a new item is taken once, of the four loading cells at the tail of the chain,
// the upper three are empty and the lowest is empty or moving on.
// Reset: rst_n low clears the chain, homes the cursor to row 0, column 0 and
// restores the register defaults (80 columns, 25 rows, cursor glyph 127,
// black text, scroll top row 4).
// Stall: with out_stall high the head command holds, the chain backs up and
// in_stall rises once the loading cells cannot drain.
`include "text_console_cursor_engine_top_defines.svh"

module text_console_cursor_engine_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_char_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_op,
  output logic [7:0]                         out_glyph,
  output logic [5:0]                         out_cell_row,
  output logic [6:0]                         out_cell_col,
  output logic [23:0]                        out_pixel_color,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int N    = tcce_pkg::CHAIN_LEN;
  localparam int BASE = tcce_pkg::LOAD_BASE;

  tcce_pkg::cfg_t  cfg_r;
  logic [5:0]      cursor_row_r;
  logic [6:0]      cursor_col_r;
  logic [5:0]      row_nxt;
  logic [6:0]      col_nxt;
  tcce_pkg::slot_t load_slots [tcce_pkg::LOAD_SLOTS];
  tcce_pkg::slot_t chain [N];
  logic [N-1:0]    adv;
  logic [N-1:0]    occ;
  logic            in_take;

  // Configuration registers: keep only the low bits of each register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns      <= tcce_pkg::RST_COLUMNS;
      cfg_r.rows         <= tcce_pkg::RST_ROWS;
      cfg_r.cursor_glyph <= tcce_pkg::RST_CURSOR;
      cfg_r.text_color   <= tcce_pkg::RST_COLOR;
      cfg_r.scroll_top   <= tcce_pkg::RST_SCROLL_TOP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcce_pkg::REG_COLUMNS:    cfg_r.columns      <= cfg_data[6:0];
        tcce_pkg::REG_ROWS:       cfg_r.rows         <= cfg_data[5:0];
        tcce_pkg::REG_CURSOR:     cfg_r.cursor_glyph <= cfg_data[7:0];
        tcce_pkg::REG_COLOR:      cfg_r.text_color   <= cfg_data[23:0];
        tcce_pkg::REG_SCROLL_TOP: cfg_r.scroll_top   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Decode the character against the current cursor.
  tcce_decode u_decode (
    .char_code (in_char_code),
    .cur_row   (cursor_row_r),
    .cur_col   (cursor_col_r),
    .cfg       (cfg_r),
    .slots     (load_slots),
    .new_row   (row_nxt),
    .new_col   (col_nxt)
  );

  // Take an item when every cell above the load base is empty and the
  // load base itself moves on this cycle.
  assign in_stall = (|occ[N-1:BASE+1]) || !adv[BASE];
  assign in_take  = in_valid && !in_stall;

  // Advance the cursor on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_row_r <= 6'd0;
      cursor_col_r <= 7'd0;
    end else if (in_take) begin
      cursor_row_r <= row_nxt;
      cursor_col_r <= col_nxt;
    end
  end

  // Command chain: cell 0 is the output, new commands load at the tail.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            adv_dn;
    logic            ld_en;
    tcce_pkg::cmd_t  ld_cmd;
    tcce_pkg::slot_t up;

    if (i == 0) begin : g_head
      assign adv_dn = !out_stall;
    end else begin : g_body
      assign adv_dn = adv[i-1];
    end

    if (i == N - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = chain[i+1];
    end

    if (i >= BASE) begin : g_load
      assign ld_en  = in_take && load_slots[i-BASE].valid;
      assign ld_cmd = load_slots[i-BASE].cmd;
    end else begin : g_plain
      assign ld_en  = 1'b0;
      assign ld_cmd = '0;
    end

    tcce_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv_in  (adv_dn),
      .adv_out (adv[i]),
      .ld_en   (ld_en),
      .ld_cmd  (ld_cmd),
      .up      (up),
      .q       (chain[i])
    );

    assign occ[i] = chain[i].valid;
  end

  // Drive the result ports from the head cell.
  assign out_valid       = chain[0].valid;
  assign out_op          = chain[0].cmd.op;
  assign out_glyph       = chain[0].cmd.glyph;
  assign out_cell_row    = chain[0].cmd.row;
  assign out_cell_col    = chain[0].cmd.col;
  assign out_pixel_color = chain[0].cmd.color;
  assign out_last        = chain[0].cmd.last;

  // The first command of every accepted item lands in the load base cell.
  `TCCE_ASSERT_NEXT(a_load_lands, in_take, occ[BASE], "accepted item did not load")
  // A stalled head command holds in place.
  `TCCE_ASSERT_NEXT(a_head_holds, out_valid && out_stall, $stable(chain[0]), "stalled head moved")
  // The cursor column never reaches the register ceiling.
  `TCCE_ASSERT_NOW(a_col_bound, 1'b1, cursor_col_r != 7'd127, "cursor column out of range")

endmodule

// ----- tb/sv/text_console_cursor_engine_cmd_check.sv -----
// Command checker for the text console cursor engine: tracks the cursor and compares every command.
module text_console_cursor_engine_cmd_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_char_code,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_op,
  input  logic [7:0]                      out_glyph,
  input  logic [5:0]                      out_cell_row,
  input  logic [6:0]                      out_cell_col,
  input  logic [23:0]                     out_pixel_color,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              cmds_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers and cursor position.
  logic [6:0]  lim_cols;
  logic [5:0]  lim_rows;
  logic [7:0]  cursor_code;
  logic [23:0] ink;
  logic [5:0]  scroll_top;
  logic [5:0]  cur_row;
  logic [6:0]  cur_col;

  tcce_pkg::cmd_t pending_cmds[$];
  tcce_pkg::cmd_t burst [4];
  int             burst_n;

  function automatic tcce_pkg::cmd_t make_cmd(input tcce_pkg::op_t op, input logic [7:0] g,
                                              input logic [5:0] r, input logic [6:0] c,
                                              input logic [23:0] color);
    tcce_pkg::cmd_t cmd;
    cmd.op    = op;
    cmd.glyph = g;
    cmd.row   = r;
    cmd.col   = c;
    cmd.color = color;
    cmd.last  = 1'b0;
    return cmd;
  endfunction

  task automatic add_cmd(input tcce_pkg::cmd_t cmd);
    burst[burst_n] = cmd;
    burst_n++;
  endtask

  // Step one row down; at the bottom hold the last row and scroll.
  task automatic step_down(input int nrows);
    int r;
    r = int'(cur_row) + 1;
    if (r >= nrows) begin
      r = nrows - 1;
      add_cmd(make_cmd(tcce_pkg::OP_SCROLL, 8'd0, scroll_top, 7'd0, 24'd0));
    end
    cur_row = r[5:0];
  endtask

  task automatic predict_commands(input logic [7:0] ch);
    int   ncols;
    int   nrows;
    int   c;
    logic redraw;
    ncols = (lim_cols == 0) ? 1 : int'(lim_cols);
    if (ncols > tcce_pkg::MAX_COLS) ncols = tcce_pkg::MAX_COLS;
    nrows = (lim_rows == 0) ? 1 : int'(lim_rows);
    if (nrows > tcce_pkg::MAX_ROWS) nrows = tcce_pkg::MAX_ROWS;
    redraw  = 1'b1;
    burst_n = 0;
    add_cmd(make_cmd(tcce_pkg::OP_ERASE, cursor_code, cur_row, cur_col, 24'd0));
    if (ch == tcce_pkg::CH_CR) begin
      cur_col = 7'd0;
    end else if (ch == tcce_pkg::CH_LF) begin
      step_down(nrows);
    end else if (ch == tcce_pkg::CH_BS) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 7'd1;
        add_cmd(make_cmd(tcce_pkg::OP_CLEAR, 8'd0, cur_row, cur_col, 24'd0));
      end else begin
        redraw = 1'b0;
      end
    end else begin
      add_cmd(make_cmd(tcce_pkg::OP_DRAW, ch, cur_row, cur_col, ink));
      c = int'(cur_col) + 1;
      if (c >= ncols) begin
        c = 0;
        step_down(nrows);
      end
      cur_col = c[6:0];
    end
    if (redraw) add_cmd(make_cmd(tcce_pkg::OP_DRAW, cursor_code, cur_row, cur_col, ink));
    burst[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) pending_cmds.push_back(burst[i]);
  endtask

  task automatic report(input string what, input tcce_pkg::cmd_t want,
                        input tcce_pkg::cmd_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected op=%0d glyph=%0d row=%0d col=%0d color=%06h last=%0b",
               $time, what, want.op, want.glyph, want.row, want.col, want.color, want.last);
      $display("            actual op=%0d glyph=%0d row=%0d col=%0d color=%06h last=%0b",
               got.op, got.glyph, got.row, got.col, got.color, got.last);
    end
  endtask

  task automatic check_cmd(input tcce_pkg::cmd_t got);
    tcce_pkg::cmd_t want;
    cmds_checked++;
    if (pending_cmds.size() == 0) begin
      report("command with nothing pending", '0, got);
    end else begin
      want = pending_cmds.pop_front();
      if (got.op !== want.op || got.glyph !== want.glyph || got.row !== want.row ||
          got.col !== want.col || got.color !== want.color || got.last !== want.last)
        report("command mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_cols     = tcce_pkg::RST_COLUMNS;
      lim_rows     = tcce_pkg::RST_ROWS;
      cursor_code  = tcce_pkg::RST_CURSOR;
      ink          = tcce_pkg::RST_COLOR;
      scroll_top   = tcce_pkg::RST_SCROLL_TOP;
      cur_row      = 6'd0;
      cur_col      = 7'd0;
      mismatches   = 0;
      cmds_checked = 0;
      pending_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcce_pkg::REG_COLUMNS:    lim_cols    = cfg_data[6:0];
          tcce_pkg::REG_ROWS:       lim_rows    = cfg_data[5:0];
          tcce_pkg::REG_CURSOR:     cursor_code = cfg_data[7:0];
          tcce_pkg::REG_COLOR:      ink         = cfg_data[23:0];
          tcce_pkg::REG_SCROLL_TOP: scroll_top  = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_commands(in_char_code);
      if (out_valid && !out_stall)
        check_cmd({tcce_pkg::op_t'(out_op), out_glyph, out_cell_row, out_cell_col,
                   out_pixel_color, out_last});
    end
    outstanding <= pending_cmds.size();
  end

endmodule

// ----- tb/sv/text_console_cursor_engine_top_test.sv -----
// Top of the cursor engine testbench: clock, reset, character and register stimulus, verdict.
module text_console_cursor_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_char_code = 8'd0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic [1:0]                      out_op;
  logic [7:0]                      out_glyph;
  logic [5:0]                      out_cell_row;
  logic [6:0]                      out_cell_col;
  logic [23:0]                     out_pixel_color;
  logic                            out_last;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  int mismatches;
  int outstanding;
  int cmds_checked;

  // Idle percentages of the two sides; changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cfg_writes    = 0;

  text_console_cursor_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op          (out_op),
    .out_glyph       (out_glyph),
    .out_cell_row    (out_cell_row),
    .out_cell_col    (out_cell_col),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  text_console_cursor_engine_cmd_check u_cmd_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op          (out_op),
    .out_glyph       (out_glyph),
    .out_cell_row    (out_cell_row),
    .out_cell_col    (out_cell_col),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .cmds_checked    (cmds_checked)
  );

  always #4 clk = ~clk;

  // Receiver side: stall the command channel at random, once per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one character and hold it until taken. Valid stays high afterwards so that
  // back-to-back items never lower and raise it in the same step; the next call or
  // settle() decides whether it drops.
  task automatic send_char(input logic [7:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted command has come out, then let the
  // pipeline run dry before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write; valid drops after each write.
  task automatic write_reg(input logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcce_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Write all five registers; the bits above each register's width carry noise,
  // which the block must drop.
  task automatic load_config(input logic [6:0] cols, input logic [5:0] nrows,
                             input logic [7:0] cursor, input logic [23:0] color,
                             input logic [5:0] top);
    logic [tcce_pkg::CFG_DATA_W-1:0] data;
    logic [31:0]                     rnd;
    rnd = $urandom(); data = rnd[tcce_pkg::CFG_DATA_W-1:0]; data[6:0] = cols;
    write_reg(tcce_pkg::REG_COLUMNS, data);
    rnd = $urandom(); data = rnd[tcce_pkg::CFG_DATA_W-1:0]; data[5:0] = nrows;
    write_reg(tcce_pkg::REG_ROWS, data);
    rnd = $urandom(); data = rnd[tcce_pkg::CFG_DATA_W-1:0]; data[7:0] = cursor;
    write_reg(tcce_pkg::REG_CURSOR, data);
    write_reg(tcce_pkg::REG_COLOR, color);
    rnd = $urandom(); data = rnd[tcce_pkg::CFG_DATA_W-1:0]; data[5:0] = top;
    write_reg(tcce_pkg::REG_SCROLL_TOP, data);
  endtask

  // Mostly ordinary bytes, with enough control codes to move the cursor around.
  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return tcce_pkg::CH_LF;
    if (pick < 18) return tcce_pkg::CH_CR;
    if (pick < 30) return tcce_pkg::CH_BS;
    return 8'($urandom_range(255));
  endfunction

  // One random phase: fresh limits (small ones most of the time, so that wrap and
  // scroll come often), sometimes a write past the register list, then characters.
  task automatic random_phase(input int n_items, input logic force_wide);
    logic [6:0] cols;
    logic [5:0] nrows;
    settle();
    case ($urandom_range(7))
      0:       cols = 7'd0;
      1:       cols = 7'd127;
      default: cols = 7'($urandom_range(1, 6));
    endcase
    case ($urandom_range(7))
      0:       nrows = 6'd0;
      1:       nrows = 6'd63;
      default: nrows = 6'($urandom_range(1, 5));
    endcase
    if (force_wide)
      load_config(7'd127, 6'd63, 8'd255, 24'd0, 6'd62);
    else
      load_config(cols, nrows, 8'($urandom_range(255)), 24'($urandom()),
                  6'($urandom_range(63)));
    if ($urandom_range(1) == 1)
      write_reg(tcce_pkg::REG_SCROLL_TOP + 3'($urandom_range(1, 3)), 24'($urandom()));
    repeat (n_items) send_char(random_char());
  endtask

  initial begin
    // Reset defaults (80 x 25): backspace at column zero, byte extremes, backspace
    // back to column zero and past it, return, line feeds; ends at row 2, column 3.
    logic [7:0] opening [16] = '{tcce_pkg::CH_BS, 8'h00, 8'hFF, "A",
                                 tcce_pkg::CH_BS, tcce_pkg::CH_BS,
                                 tcce_pkg::CH_BS, tcce_pkg::CH_BS,
                                 tcce_pkg::CH_CR, 8'h7F, tcce_pkg::CH_CR,
                                 tcce_pkg::CH_LF, tcce_pkg::CH_LF, "a", "b", "c"};
    // With one column and one row: the cursor now lies outside both limits.
    logic [7:0] squeezed [5] = '{"Z", tcce_pkg::CH_LF, tcce_pkg::CH_BS, 8'h20,
                                 tcce_pkg::CH_CR};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 84;
    foreach (opening[i]) send_char(opening[i]);

    // Writes past the register list must change nothing.
    settle();
    write_reg(tcce_pkg::REG_SCROLL_TOP + 3'd1, 24'h000001);
    write_reg(tcce_pkg::REG_SCROLL_TOP + 3'd3, 24'hFFFFFF);
    // Zero columns and rows by truncation (act as one), cursor glyph 0, white ink,
    // scroll top 63, beyond the row count.
    write_reg(tcce_pkg::REG_COLUMNS, 24'hFFFF80);
    write_reg(tcce_pkg::REG_ROWS, 24'hFFFFC0);
    write_reg(tcce_pkg::REG_CURSOR, 24'h000000);
    write_reg(tcce_pkg::REG_COLOR, 24'hFFFFFF);
    write_reg(tcce_pkg::REG_SCROLL_TOP, 24'hFFFFFF);
    foreach (squeezed[i]) send_char(squeezed[i]);

    // Random part: slow receiver, then slow sender, then both at full rate.
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 15; recv_idle_pct = 84; end
        1: begin send_idle_pct = 84; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      random_phase(25, p == 0);
    end

    settle();
    repeat (12) @(posedge clk);
    $display("Sent %0d characters and %0d register writes; checked %0d commands.",
             items_sent, cfg_writes, cmds_checked);
    $display("Covered wrap, scroll, backspace at column zero, one-cell and widest limits.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
